/* hdl/lcdns_pkg.sv */
// Package with the shared types, constants and the init table of the LCD nibble sequencer.
package lcdns_pkg;

    // Command codes carried in the mode field.
    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_CURSOR = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_DELAY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_DELAY = 2'd1;
    localparam int CFG_DATA_W = 13;

    // Register reset values.
    localparam logic [9:0]  WRITE_DELAY_RESET = 10'd46;
    localparam logic [12:0] CLEAR_DELAY_RESET = 13'd1000;

    // Fixed values used by the command decoder.
    localparam logic [7:0]  DDRAM_BASE   = 8'h80;
    localparam logic [7:0]  ROW_OFFSET   = 8'h40;
    localparam logic [5:0]  MAX_COLUMN   = 6'd39;
    localparam logic [12:0] CURSOR_POST  = 13'd40;
    localparam logic [12:0] SHORT_POST   = 13'd1;
    localparam logic [12:0] CHAR_EXTRA   = 13'd2;

    // Init sequence length and strobe counter width.
    localparam int INIT_LEN = 12;
    localparam int STEP_W   = $clog2(INIT_LEN);
    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_LEN - 1);

    // Command queue depth.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input word.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic       row;
        logic [5:0] column;
    } lcd_in_t;

    // Output word: one enable strobe.
    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [13:0] pre_delay_us;
        logic [12:0] post_delay_us;
        logic        last;
    } lcd_out_t;

    // Classified command handed from the front end to the strobe sequencer.
    typedef struct packed {
        logic        is_init;
        logic        reg_select;
        logic [3:0]  nib_hi;
        logic [3:0]  nib_lo;
        logic        pre_one;
        logic [12:0] post_hi;
        logic [12:0] post_lo;
    } lcd_cmd_t;

    // One strobe of the fixed wake-up sequence; RS is always low.
    function automatic lcd_out_t init_strobe(input logic [STEP_W-1:0] idx);
        lcd_out_t s;
        s = '0;
        unique case (idx)
            4'd0:    begin s.nibble = 4'h3; s.pre_delay_us = 14'd15000; end
            4'd1:    begin s.nibble = 4'h3; s.pre_delay_us = 14'd4100;  end
            4'd2:
            begin
                s.nibble = 4'h3; s.pre_delay_us = 14'd110; s.post_delay_us = 13'd1;
            end
            4'd3:    begin s.nibble = 4'h2; s.post_delay_us = 13'd40;   end
            4'd4:    begin s.nibble = 4'h2; s.post_delay_us = 13'd1;    end
            4'd5:    begin s.nibble = 4'h8; s.post_delay_us = 13'd40;   end
            4'd6:    begin s.nibble = 4'h0; s.post_delay_us = 13'd1;    end
            4'd7:    begin s.nibble = 4'h8; s.post_delay_us = 13'd40;   end
            4'd8:    begin s.nibble = 4'h0; s.post_delay_us = 13'd1;    end
            4'd9:    begin s.nibble = 4'h1; s.post_delay_us = 13'd1000; end
            4'd10:   begin s.nibble = 4'h0; s.post_delay_us = 13'd1;    end
            4'd11:   begin s.nibble = 4'h7; s.post_delay_us = 13'd40;   end
            default: s = '0;
        endcase
        s.last = (idx == INIT_LAST);
        return s;
    endfunction

endpackage

/* hdl/char_lcd_nibble_sequencer_top.sv */
// Top level of the character LCD nibble sequencer for a 4-bit HD44780 bus.
//
// Each accepted command word turns into a run of strobe words on the output:
// twelve for init, two for write character, clear display and move cursor.
// The sequencer sends one strobe word per clock cycle when the output is not
// stalled; a two-entry command queue sits between the command decoder and
// the sequencer, so new commands are taken while earlier ones are still
// being sent, and the input stalls only when that queue is full. The first
// strobe of a command passes through the queue entry, the command register
// and then the output register. Configuration writes are always ready and
// must only be issued while no command is in flight; the write delay
// register applies to character strobes and the clear delay register to the
// clear command.
module char_lcd_nibble_sequencer_top
    import lcdns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lcd_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lcd_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    lcd_cmd_t front_cmd;
    lcd_cmd_t q_data;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    // Command decoder and configuration registers.
    lcdns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_in    (in_data),
        .cmd_out   (front_cmd)
    );

    // Queue of decoded commands.
    lcdns_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Strobe sequencer and output register.
    lcdns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* hdl/lcdns_front.sv */
// Front end: configuration registers and decoding of each command into a strobe plan.
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  lcd_in_t                cmd_in,
    output lcd_cmd_t               cmd_out
);

    logic [9:0]  write_delay_reg;
    logic [12:0] clear_delay_reg;
    logic [5:0]  col_clamped;
    logic [7:0]  cursor_addr;
    logic [12:0] char_post;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_delay_reg <= WRITE_DELAY_RESET;
            clear_delay_reg <= CLEAR_DELAY_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WRITE_DELAY)
            begin
                write_delay_reg <= cfg_data[9:0];
            end
            else if (cfg_index == REG_CLEAR_DELAY)
            begin
                clear_delay_reg <= cfg_data;
            end
        end
    end

    // Cursor address and character settle time.
    assign col_clamped = (cmd_in.column > MAX_COLUMN) ? MAX_COLUMN : cmd_in.column;
    assign cursor_addr = DDRAM_BASE + (cmd_in.row ? ROW_OFFSET : 8'd0) + {2'b00, col_clamped};
    assign char_post   = {3'b000, write_delay_reg} + CHAR_EXTRA;

    // Decode the command into the two-strobe plan, or flag the init sequence.
    always_comb
    begin
        cmd_out = '0;
        unique case (cmd_in.mode)
            MODE_INIT:
            begin
                cmd_out.is_init = 1'b1;
            end
            MODE_WRITE:
            begin
                cmd_out.reg_select = 1'b1;
                cmd_out.nib_hi     = cmd_in.char_code[7:4];
                cmd_out.nib_lo     = cmd_in.char_code[3:0];
                cmd_out.pre_one    = 1'b1;
                cmd_out.post_hi    = char_post;
                cmd_out.post_lo    = char_post;
            end
            MODE_CLEAR:
            begin
                cmd_out.nib_hi  = 4'h0;
                cmd_out.nib_lo  = 4'h1;
                cmd_out.post_hi = SHORT_POST;
                cmd_out.post_lo = clear_delay_reg;
            end
            MODE_CURSOR:
            begin
                cmd_out.nib_hi  = cursor_addr[7:4];
                cmd_out.nib_lo  = cursor_addr[3:0];
                cmd_out.post_hi = SHORT_POST;
                cmd_out.post_lo = CURSOR_POST;
            end
            default: cmd_out = '0;
        endcase
    end

endmodule

/* hdl/lcdns_queue.sv */
// Short command queue between the decoder and the strobe sequencer.
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lcd_cmd_t push_data,
    input  logic     pop,
    output lcd_cmd_t pop_data,
    output logic     full,
    output logic     empty
);

    lcd_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? ((wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

    // The write and read pointers meet only when the queue is empty or full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) |-> (empty || full))
    else $error("queue pointers inconsistent with count");

endmodule

/* hdl/lcdns_back.sv */
// Back end: walks each queued command through its strobes into the output register.
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lcd_cmd_t q_data,
    input  logic     q_empty,
    output logic     q_pop,
    output logic     out_valid,
    input  logic     out_stall,
    output lcd_out_t out_data
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    lcd_cmd_t          cmd_reg;
    logic              out_valid_reg, out_valid_next;
    lcd_out_t          out_data_reg;
    logic              out_free;
    logic              emit;
    lcd_out_t          strobe;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && out_free;

    // Strobe for the current step of the current command.
    always_comb
    begin
        if (cmd_reg.is_init)
        begin
            strobe = init_strobe(step_reg);
        end
        else
        begin
            strobe               = '0;
            strobe.reg_select    = cmd_reg.reg_select;
            strobe.nibble        = step_reg[0] ? cmd_reg.nib_lo : cmd_reg.nib_hi;
            strobe.pre_delay_us  = {13'd0, cmd_reg.pre_one};
            strobe.post_delay_us = step_reg[0] ? cmd_reg.post_lo : cmd_reg.post_hi;
            strobe.last          = step_reg[0];
        end
    end

    // Take the next command when idle or while the last strobe leaves.
    assign q_pop = !q_empty && (!busy_reg || (emit && strobe.last));

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (emit)
        begin
            step_next = step_reg + 1'b1;
            if (strobe.last)
            begin
                busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (emit)
        begin
            out_data_reg <= strobe;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The init step never runs past the end of its table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cmd_reg.is_init) |-> (step_reg <= INIT_LAST))
    else $error("init step out of range");

    // Two-strobe commands use only steps zero and one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !cmd_reg.is_init) |-> (step_reg <= STEP_W'(1)))
    else $error("two-strobe command past its second strobe");

    // A last strobe sent with nothing queued leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && strobe.last && q_empty) |=> !busy_reg)
    else $error("sequencer busy after final strobe");

endmodule
